// ===== rtl/dpt_pkg.sv =====
// dpt_pkg: shared widths, codes and types for the delayed periodic timer.
// No dependencies; imported by every rtl/dpt_* module and the top level.
package dpt_pkg;

  localparam int TIME_WIDTH  = 32;  // elapsed/goal width, 8..64
  localparam int COUNT_WIDTH = 32;  // pending count width, 4..32

  localparam int DELAY_W  = 31;
  localparam int PERIOD_W = 31;
  localparam int DELTA_W  = 16;
  localparam int CFG_W    = 31;     // widest config register
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W    = 32;     // fired / pending output field width

  localparam int IN_DATA_W  = 24;   // delta(16) + new_status(2), byte padded
  localparam int OUT_DATA_W = 72;   // 32 + 1 + 2 + 32 = 67, byte padded

  localparam int CNT_W = $clog2(TIME_WIDTH + 1);
  localparam int SUM_TW = ((TIME_WIDTH > DELTA_W) ? TIME_WIDTH : DELTA_W) + 1;
  localparam int GOAL_W = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
  localparam int PEND_W = ((TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH) + 1;

  localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = {TIME_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_SERVICE_ALL = 3'd1,
    ACT_SERVICE_ONE = 3'd2,
    ACT_SET_STATUS  = 3'd3,
    ACT_ABORT       = 3'd4,
    ACT_RESTART     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_PLAY    = 2'd0,
    ST_PAUSED  = 2'd1,
    ST_ABORTED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_DELAY = 2'd0,
    REG_PERIOD      = 2'd1,
    REG_LOOPED      = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } seq_state_t;

endpackage

// ===== rtl/dpt_cfg.sv =====
// dpt_cfg: configuration registers and the derived start goal / period.
// Depends on dpt_pkg.
module dpt_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpt_pkg::CFG_W-1:0]         cfg_data,
  output logic                              looped,
  output logic [dpt_pkg::TIME_WIDTH-1:0]    start_goal,
  output logic [dpt_pkg::TIME_WIDTH-1:0]    eff_period
);
  import dpt_pkg::*;

  logic [DELAY_W-1:0]  first_delay;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] per1;
  logic [GOAL_W-1:0]   goal_sum;
  logic [GOAL_W-1:0]   per_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= '0;
      period      <= PERIOD_W'(1);
      looped      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_DELAY: first_delay <= cfg_data[DELAY_W-1:0];
        REG_PERIOD:      period      <= cfg_data[PERIOD_W-1:0];
        REG_LOOPED:      looped      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero period acts as one; both values clamp to the time range
  assign per1     = (period == '0) ? PERIOD_W'(1) : period;
  assign per_ext  = GOAL_W'(per1);
  assign goal_sum = GOAL_W'(first_delay) + per_ext;

  assign start_goal = (goal_sum > GOAL_W'(TIME_MAX)) ? TIME_MAX : goal_sum[TIME_WIDTH-1:0];
  assign eff_period = (per_ext > GOAL_W'(TIME_MAX)) ? TIME_MAX : per_ext[TIME_WIDTH-1:0];

endmodule

// ===== rtl/dpt_div.sv =====
// dpt_div: restoring divider, one quotient bit per cycle.
// Depends on dpt_pkg.
module dpt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dpt_pkg::TIME_WIDTH-1:0] dividend,
  input  logic [dpt_pkg::TIME_WIDTH-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [dpt_pkg::TIME_WIDTH-1:0] quotient,
  output logic [dpt_pkg::TIME_WIDTH-1:0] remainder
);
  import dpt_pkg::*;

  logic [TIME_WIDTH-1:0] dvs;
  logic [CNT_W-1:0]      cnt;
  logic [TIME_WIDTH:0]   trial;
  logic                  fits;

  assign trial = {remainder, quotient[TIME_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TIME_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[TIME_WIDTH-2:0], fits};
      if (fits) begin
        remainder <= TIME_WIDTH'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[TIME_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== rtl/delayed_periodic_timer.sv =====
// delayed_periodic_timer: top level, sequencer, timer state and stream ports.
// Depends on dpt_pkg, dpt_cfg and dpt_div.
//
// Periodic timer with a first delay, counting whole ticks. Each input word
// carries an action (s_tuser) and its operands (s_tdata); each one yields
// exactly one result word with the fired count, ready flag, status and
// pending count as they stand after the action. Words are taken one at a
// time: an action that does not expire the timer passes the accept step,
// then the result stage; a tick that reaches the goal passes the accept
// step, the division state, in which the restoring divider makes the
// elapsed / goal split, a step that folds quotient and remainder into
// the timer state, and the result stage. A finished result sits in the
// output register, so the next word can be accepted while it waits to be
// taken. Configuration writes take effect on the goal only at restart and
// expiry; reset sets the goal to 1.
module delayed_periodic_timer (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpt_pkg::CFG_W-1:0]         cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dpt_pkg::IN_DATA_W-1:0]     s_tdata,   // delta_ticks[15:0], new_status[17:16]
  input  logic [2:0]                        s_tuser,   // action[2:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dpt_pkg::OUT_DATA_W-1:0]    m_tdata    // fired[31:0], ready_res[32],
                                                       // status[34:33], pending[66:35]
);
  import dpt_pkg::*;

  // config
  logic                  looped;
  logic [TIME_WIDTH-1:0] start_goal;
  logic [TIME_WIDTH-1:0] eff_period;

  // timer state
  seq_state_t             state;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [TIME_WIDTH-1:0]  goal;
  logic [COUNT_WIDTH-1:0] pending_count;
  status_t                run_status;
  logic                   armed;
  logic [OUT_W-1:0]       fired;

  // divider
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [TIME_WIDTH-1:0] div_q;
  logic [TIME_WIDTH-1:0] div_r;

  // decoded input word
  action_t              action;
  logic [DELTA_W-1:0]   delta_ticks;
  logic [1:0]           new_status;
  logic                 accept;

  logic [SUM_TW-1:0]     tick_sum;
  logic [TIME_WIDTH-1:0] elapsed_sat;
  logic [TIME_WIDTH-1:0] goal_nz;
  logic                  expire;
  logic [PEND_W-1:0]     pend_sum;
  logic                  out_free;
  logic                  out_load;
  logic                  ready_res;
  logic [OUT_W-1:0]      svc_fired;

  dpt_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .looped     (looped),
    .start_goal (start_goal),
    .eff_period (eff_period)
  );

  dpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (elapsed_sat),
    .divisor   (goal_nz),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign action      = action_t'(s_tuser);
  assign delta_ticks = s_tdata[DELTA_W-1:0];
  assign new_status  = s_tdata[DELTA_W+1:DELTA_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_DONE) && out_free;

  // tick arithmetic: saturating add, then compare against the goal
  assign tick_sum    = SUM_TW'(elapsed) + SUM_TW'(delta_ticks);
  assign elapsed_sat = (tick_sum > SUM_TW'(TIME_MAX)) ? TIME_MAX
                                                      : tick_sum[TIME_WIDTH-1:0];
  assign goal_nz     = (goal == '0) ? TIME_WIDTH'(1) : goal;
  assign expire      = elapsed_sat >= goal_nz;
  assign div_start   = accept && (action == ACT_TICK) && (run_status == ST_PLAY) && expire;

  // saturating add of the quotient into the pending count
  assign pend_sum = PEND_W'(div_q) + PEND_W'(pending_count);

  assign ready_res = (run_status == ST_PLAY) && armed && (pending_count != '0);

  // events fired by a service word: one-shot and service-once fire one,
  // looped service-all fires the whole pending count
  always_comb begin
    svc_fired = '0;
    if ((action == ACT_SERVICE_ALL || action == ACT_SERVICE_ONE) &&
        run_status == ST_PLAY && armed) begin
      if (!looped || action == ACT_SERVICE_ONE) begin
        svc_fired = OUT_W'(1);
      end else begin
        svc_fired = OUT_W'(pending_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      elapsed       <= '0;
      goal          <= TIME_WIDTH'(1);   // first_delay 0 + period 1
      pending_count <= '0;
      run_status    <= ST_PLAY;
      armed         <= 1'b1;
      fired         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fired <= svc_fired;
            state <= div_start ? S_DIV : S_DONE;
            case (action)
              ACT_TICK: begin
                if (run_status == ST_PLAY && !expire) begin
                  elapsed <= elapsed_sat;
                end
              end
              ACT_SERVICE_ALL, ACT_SERVICE_ONE: begin
                if (run_status == ST_PLAY && armed) begin
                  pending_count <= '0;
                  if (!looped) begin
                    // one-shot: fire once, then abort
                    armed      <= 1'b0;
                    run_status <= ST_ABORTED;
                  end
                end
              end
              ACT_SET_STATUS: begin
                // unknown status code leaves the status alone
                if (new_status <= ST_ABORTED) begin
                  run_status <= status_t'(new_status);
                end
              end
              ACT_ABORT: begin
                armed         <= 1'b0;
                pending_count <= '0;
                run_status    <= ST_ABORTED;
              end
              ACT_RESTART: begin
                run_status <= ST_PLAY;
                elapsed    <= '0;
                goal       <= start_goal;
                armed      <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            elapsed <= div_r;
            goal    <= eff_period;
            if (pend_sum > PEND_W'(COUNT_MAX)) begin
              pending_count <= COUNT_MAX;
            end else begin
              pending_count <= pend_sum[COUNT_WIDTH-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded from state as it stands after the word
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, OUT_W'(pending_count), run_status, ready_res, fired};
    end
  end

  // no input is taken while the divider works
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !s_tready)
    else $error("input accepted while divider busy");

  // an abort word leaves the timer disarmed with nothing pending
  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_ABORT) |=> (!armed && pending_count == '0 &&
                                         run_status == ST_ABORTED))
    else $error("abort did not clear timer");

  // a result that reports ready must also report play status
  a_ready_implies_play: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[34:33] == ST_PLAY))
    else $error("ready_res set without play status");

  // the divider only runs from the division state
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside division state");

endmodule

// ===== test/delayed_periodic_timer_tb.sv =====
// delayed_periodic_timer_tb: self-checking testbench for the delayed periodic timer.
// Needs dpt_pkg and the rtl/ sources; each result is checked by a timer predictor or the table.
// Directed table first, then random phases over several register settings and idle patterns.
module delayed_periodic_timer_tb;
  import dpt_pkg::*;

  // action and status codes outside the package range
  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam int HOLD_CYCLES = 300;             // long receiver hold-off
  localparam int TAIL_CYCLES = TIME_WIDTH + 4;  // divider latency plus margin

  typedef struct packed {
    logic [OUT_W-1:0] fired;
    logic             ready;
    status_t          status;
    logic [OUT_W-1:0] pending;
  } timer_res_t;

  typedef struct {
    logic [DELAY_W-1:0]  delay;
    logic [PERIOD_W-1:0] period;
    logic                looped;
  } cfg_set_t;

  // cfg_set != 0: drain, then load that register set before the word
  typedef struct {
    int unsigned  cfg_set;
    logic [2:0]   act;
    logic [15:0]  delta;
    logic [1:0]   ns;
    bit           typed;
    timer_res_t   want;
  } drow_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  delayed_periodic_timer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor copy of registers and timer state
  logic [DELAY_W-1:0]     c_delay;
  logic [PERIOD_W-1:0]    c_period;
  logic                   c_looped;
  logic [TIME_WIDTH-1:0]  t_elapsed;
  logic [TIME_WIDTH-1:0]  t_goal;
  logic [COUNT_WIDTH-1:0] t_pending;
  status_t                t_status;
  logic                   t_armed;

  timer_res_t awaited[$];   // result words still owed by the block
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  cfg_set_t cfg_sets [3] = '{
    '{31'd0, 31'd1, 1'b0},
    '{31'd10, 31'd0, 1'b1},                  // zero period counts as one
    '{31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1}      // both registers at max
  };

  // power-on registers: first_delay 0, period 1, one-shot -> goal 1
  drow_t directed [26] = '{
    '{0, ACT_TICK,        16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_TICK,        16'hFFFF,  ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd65535}},
    '{0, ACT_SET_STATUS,  16'd0,     ST_PAUSED,  1, '{32'd0, 1'b0, ST_PAUSED,  32'd65535}},
    '{0, ACT_SERVICE_ALL, 16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PAUSED,  32'd65535}},
    '{0, ACT_TICK,        16'd5,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PAUSED,  32'd65535}},
    '{0, ACT_SET_STATUS,  16'd0,     ST_UNKNOWN, 1, '{32'd0, 1'b0, ST_PAUSED,  32'd65535}},
    '{0, ACT_SET_STATUS,  16'd0,     ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd65535}},
    '{0, ACT_UNUSED6,     16'hFFFF,  ST_ABORTED, 1, '{32'd0, 1'b1, ST_PLAY,    32'd65535}},
    '{0, ACT_UNUSED7,     16'hFFFF,  ST_UNKNOWN, 1, '{32'd0, 1'b1, ST_PLAY,    32'd65535}},
    '{0, ACT_SERVICE_ONE, 16'd0,     ST_PLAY,    1, '{32'd1, 1'b0, ST_ABORTED, 32'd0}},
    '{0, ACT_SERVICE_ALL, 16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_ABORTED, 32'd0}},
    '{0, ACT_RESTART,     16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_SERVICE_ALL, 16'd0,     ST_PLAY,    1, '{32'd1, 1'b0, ST_ABORTED, 32'd0}},
    '{0, ACT_RESTART,     16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_TICK,        16'd3,     ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd3}},
    '{0, ACT_SET_STATUS,  16'd0,     ST_ABORTED, 1, '{32'd0, 1'b0, ST_ABORTED, 32'd3}},
    '{0, ACT_SET_STATUS,  16'd0,     ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd3}},
    '{0, ACT_ABORT,       16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_ABORTED, 32'd0}},
    // looped, goal 10 + 1 after restart, then 1
    '{1, ACT_RESTART,     16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_TICK,        16'd25,    ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd2}},
    '{0, ACT_SERVICE_ONE, 16'd0,     ST_PLAY,    1, '{32'd1, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_TICK,        16'd4,     ST_PLAY,    1, '{32'd0, 1'b1, ST_PLAY,    32'd7}},
    '{0, ACT_SERVICE_ALL, 16'd0,     ST_PLAY,    1, '{32'd7, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_SERVICE_ALL, 16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    // both registers at max: goal just under the time limit
    '{2, ACT_RESTART,     16'd0,     ST_PLAY,    1, '{32'd0, 1'b0, ST_PLAY,    32'd0}},
    '{0, ACT_TICK,        16'hFFFF,  ST_PLAY,    0, '{32'd0, 1'b0, ST_PLAY,    32'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [TIME_WIDTH-1:0] start_goal();
    longint unsigned g;
    g = 64'(c_delay) + 64'((c_period == '0) ? 31'd1 : c_period);
    if (g > 64'(TIME_MAX)) g = 64'(TIME_MAX);
    return g[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [TIME_WIDTH-1:0] run_period();
    longint unsigned p;
    p = 64'((c_period == '0) ? 31'd1 : c_period);
    if (p > 64'(TIME_MAX)) p = 64'(TIME_MAX);
    return p[TIME_WIDTH-1:0];
  endfunction

  // applies one word to the predicted timer and returns the word it reports
  function automatic timer_res_t timer_advance(logic [2:0] act, logic [15:0] delta,
                                               logic [1:0] ns);
    timer_res_t r;
    logic [SUM_TW-1:0]     sum;
    logic [TIME_WIDTH-1:0] quo;
    logic [PEND_W-1:0]     psum;
    r.fired = '0;
    case (act)
      ACT_TICK: begin
        if (t_status == ST_PLAY) begin
          sum = SUM_TW'(t_elapsed) + SUM_TW'(delta);
          t_elapsed = (sum > SUM_TW'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
          if (t_goal == '0) t_goal = TIME_WIDTH'(1);
          if (t_elapsed >= t_goal) begin
            quo = t_elapsed / t_goal;
            t_elapsed = t_elapsed % t_goal;
            psum = PEND_W'(t_pending) + PEND_W'(quo);
            t_pending = (psum > PEND_W'(COUNT_MAX)) ? COUNT_MAX : psum[COUNT_WIDTH-1:0];
            t_goal = run_period();
          end
        end
      end
      ACT_SERVICE_ALL, ACT_SERVICE_ONE: begin
        if (t_status == ST_PLAY && t_armed) begin
          if (!c_looped) begin
            // one-shot: a single event, then the timer aborts
            r.fired = OUT_W'(1);
            t_armed = 1'b0;
            t_pending = '0;
            t_status = ST_ABORTED;
          end else if (act == ACT_SERVICE_ONE) begin
            r.fired = OUT_W'(1);
            t_pending = '0;
          end else begin
            r.fired = OUT_W'(t_pending);
            t_pending = '0;
          end
        end
      end
      ACT_SET_STATUS: begin
        if (ns != ST_UNKNOWN) t_status = status_t'(ns);
      end
      ACT_ABORT: begin
        t_armed = 1'b0;
        t_pending = '0;
        t_status = ST_ABORTED;
      end
      ACT_RESTART: begin
        t_status = ST_PLAY;
        t_elapsed = '0;
        t_goal = start_goal();
        t_armed = 1'b1;
      end
      default: ;
    endcase
    r.ready = (t_status == ST_PLAY) && t_armed && (t_pending != '0);
    r.status = t_status;
    r.pending = OUT_W'(t_pending);
    return r;
  endfunction

  // offer one word; the predictor runs at the accepting edge
  task automatic offer(logic [2:0] act, logic [15:0] delta, logic [1:0] ns,
                       bit typed, timer_res_t want);
    timer_res_t model;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 18){1'b0}}, ns, delta};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    model = timer_advance(act, delta, ns);
    awaited.push_back(typed ? want : model);
  endtask

  // stop offering, wait for every owed word, then let the divider go quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic configure(cfg_set_t cs);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIRST_DELAY;
    cfg_data  <= CFG_W'(cs.delay);
    @(posedge clk);
    cfg_index <= REG_PERIOD;
    cfg_data  <= CFG_W'(cs.period);
    @(posedge clk);
    cfg_index <= REG_LOOPED;
    cfg_data  <= CFG_W'(cs.looped);
    @(posedge clk);
    cfg_we <= 1'b0;
    c_delay  = cs.delay;
    c_period = cs.period;
    c_looped = cs.looped;
  endtask

  // mostly ticks and services so expiries keep coming; the rest perturbs status
  task automatic random_word();
    int k;
    logic [2:0]  a;
    logic [15:0] d;
    logic [1:0]  s;
    k = $urandom_range(99);
    if (k < 48)      a = ACT_TICK;
    else if (k < 60) a = ACT_SERVICE_ALL;
    else if (k < 70) a = ACT_SERVICE_ONE;
    else if (k < 80) a = ACT_SET_STATUS;
    else if (k < 85) a = ACT_ABORT;
    else if (k < 95) a = ACT_RESTART;
    else             a = ($urandom_range(1) != 0) ? ACT_UNUSED6 : ACT_UNUSED7;
    k = $urandom_range(99);
    if (k < 35)      d = 16'($urandom_range(64));
    else if (k < 65) d = 16'($urandom());
    else if (k < 80) d = 16'($urandom_range(4095));
    else if (k < 90) d = 16'hFFFF;
    else             d = '0;
    s = ($urandom_range(1) != 0) ? ST_PLAY : 2'($urandom_range(3));
    offer(a, d, s, 1'b0, '0);
  endtask

  task automatic run_phase(cfg_set_t cs, int idle, int stall, int count);
    drain();
    configure(cs);
    send_idle_pct = idle;
    recv_stall_pct <= stall;
    repeat (count) random_word();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : result_sink
    int hold_ack;
    int hold_left;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check; m_tdata holds fired, ready, status, pending from bit 0 up
  always @(posedge clk) begin : result_check
    timer_res_t got;
    timer_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.fired   = m_tdata[31:0];
      got.ready   = m_tdata[32];
      got.status  = status_t'(m_tdata[34:33]);
      got.pending = m_tdata[66:35];
      if (awaited.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word %h", m_tdata);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (got.fired !== want.fired || got.ready !== want.ready ||
            got.status !== want.status || got.pending !== want.pending) begin
          if (mismatches < 10)
            $display("result mismatch: expected fired=%0d ready=%0b status=%0d pending=%0d, ",
                     want.fired, want.ready, want.status, want.pending,
                     "got fired=%0d ready=%0b status=%0d pending=%0d",
                     got.fired, got.ready, got.status, got.pending);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_set_t cs;
    c_delay   = '0;
    c_period  = PERIOD_W'(1);
    c_looped  = 1'b0;
    t_elapsed = '0;
    t_goal    = start_goal();
    t_pending = '0;
    t_status  = ST_PLAY;
    t_armed   = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    recv_stall_pct <= 0;

    // directed: reset state, extremes, status handling, one-shot and looped service
    foreach (directed[i]) begin
      if (directed[i].cfg_set != 0) begin
        drain();
        configure(cfg_sets[directed[i].cfg_set]);
      end
      offer(directed[i].act, directed[i].delta, directed[i].ns,
            directed[i].typed, directed[i].want);
    end

    // looped, short period: frequent expiries, no idling
    cs = '{31'($urandom_range(100)), 31'($urandom_range(1, 20)), 1'b1};
    run_phase(cs, 0, 0, 130);
    // one-shot, zero period, sender mostly idle
    cs = '{31'd0, 31'd0, 1'b0};
    run_phase(cs, 79, 0, 110);
    // both registers at max, receiver mostly stalled
    run_phase(cfg_sets[2], 0, 79, 40);
    // wide periods, both sides idling
    cs = '{31'($urandom_range(5000)), 31'($urandom_range(1, 70000)), 1'b1};
    run_phase(cs, 36, 36, 130);

    // back-pressure: receiver holds off while the sender keeps offering
    cs = '{31'd3, 31'd1, 1'b1};
    drain();
    configure(cs);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= hold_req + 1;
    repeat (40) random_word();
    drain();            // sender waits until every result is back
    send_idle_pct = 36;
    recv_stall_pct <= 36;
    repeat (60) random_word();

    // random registers, full 31-bit first delay
    cs = '{31'($urandom()), 31'($urandom_range(1, 300)), 1'($urandom_range(1))};
    run_phase(cs, 0, 0, 120);

    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
